// ===== hdl/tel_pkg.sv =====
// Shared request and status codes for the timed event list.
package tel_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_ADJUST = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_FIRE   = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

// ===== hdl/tel_if.sv =====
// Request and response channel interfaces for the timed event list.
interface tel_req_if #(
  parameter int unsigned TAG_BITS  = 8,
  parameter int unsigned TIME_BITS = 32
);
  import tel_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [TAG_BITS-1:0]  event_tag;
  logic [TIME_BITS-1:0] event_time;

  modport source (output valid, req_type, event_tag, event_time, input ready);
  modport sink   (input valid, req_type, event_tag, event_time, output ready);
endinterface

interface tel_rsp_if #(
  parameter int unsigned TAG_BITS  = 8,
  parameter int unsigned TIME_BITS = 32
);
  import tel_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TAG_BITS-1:0]  fired_tag;
  logic [TIME_BITS-1:0] earliest_time;

  modport source (output valid, status, fired_tag, earliest_time, input ready);
  modport sink   (input valid, status, fired_tag, earliest_time, output ready);
endinterface

// ===== hdl/tel_cell.sv =====
// One entry of the rotating event chain: valid bit, tag and due time.
module tel_cell #(
  parameter int unsigned TAG_BITS  = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 valid_i,
  input  logic [TAG_BITS-1:0]  tag_i,
  input  logic [TIME_BITS-1:0] tm_i,
  output logic                 valid_o,
  output logic [TAG_BITS-1:0]  tag_o,
  output logic [TIME_BITS-1:0] tm_o
);

  logic                 valid_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [TIME_BITS-1:0] tm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q <= tag_i;
      tm_q  <= tm_i;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign tm_o    = tm_q;

endmodule

// ===== hdl/timed_event_list_core.sv =====
// Top level of the timed event list: cell chain plus head controller.
//
// The event table is a ring of SLOTS cells that rotates by one place per
// clock while a request is being served; the entry leaving the last cell
// passes the head logic, which may rewrite it, and re-enters at cell 0.
// Slot numbers are the order in which entries pass the head within one full
// rotation. Insert, remove, adjust, query and unknown requests take one
// rotation, after which the response is registered. Fire takes two rotations
// (find the earliest entry, then subtract its time from every valid entry and
// free it), or only the first if no entry is valid. One request is in service
// at a time; a new one is accepted once the previous response is taken or is
// being taken, so a stalled receiver stalls the input. Reset clears all valid
// bits at once; no clearing pass.
module timed_event_list_core #(
  parameter int unsigned SLOTS     = 512,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned TAG_BITS  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tel_req_if.sink          req_i,
  tel_rsp_if.source        rsp_o
);
  import tel_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SWEEP = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Latched request.
  req_e                 req_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [TIME_BITS-1:0] tm_q;

  // Position in the current rotation.
  logic [IDX_W-1:0]     cnt_q, cnt_d;
  logic                 last;

  // Scan results: action done flag and running minimum.
  logic                 done_q, done_d;
  logic                 found_q, found_d;
  logic [TIME_BITS-1:0] min_tm_q, min_tm_d;
  logic [TAG_BITS-1:0]  min_tag_q, min_tag_d;
  logic [IDX_W-1:0]     min_idx_q, min_idx_d;

  // Response register.
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [TAG_BITS-1:0]  out_tag_q, out_tag_d;
  logic [TIME_BITS-1:0] out_tm_q, out_tm_d;

  // Chain wiring.
  logic                 c_valid [SLOTS];
  logic [TAG_BITS-1:0]  c_tag   [SLOTS];
  logic [TIME_BITS-1:0] c_tm    [SLOTS];
  logic                 h_valid, n_valid;
  logic [TAG_BITS-1:0]  h_tag, n_tag;
  logic [TIME_BITS-1:0] h_tm, n_tm;
  logic                 shift;
  logic                 accept;

  assign shift = (state_q == ST_SCAN) || (state_q == ST_SWEEP);

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_first
      tel_cell #(.TAG_BITS(TAG_BITS), .TIME_BITS(TIME_BITS)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(n_valid), .tag_i(n_tag), .tm_i(n_tm),
        .valid_o(c_valid[k]), .tag_o(c_tag[k]), .tm_o(c_tm[k])
      );
    end else begin : g_next
      tel_cell #(.TAG_BITS(TAG_BITS), .TIME_BITS(TIME_BITS)) u_cell (
        .clk_i, .rst_ni, .shift_i(shift),
        .valid_i(c_valid[k-1]), .tag_i(c_tag[k-1]), .tm_i(c_tm[k-1]),
        .valid_o(c_valid[k]), .tag_o(c_tag[k]), .tm_o(c_tm[k])
      );
    end
  end

  assign h_valid = c_valid[SLOTS-1];
  assign h_tag   = c_tag[SLOTS-1];
  assign h_tm    = c_tm[SLOTS-1];

  assign last   = (cnt_q == IDX_W'(SLOTS - 1));
  assign accept = req_i.valid && req_i.ready;

  // Take a new transaction only when idle and the response slot frees up.
  assign req_i.ready   = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.fired_tag     = out_tag_q;
  assign rsp_o.earliest_time = out_tm_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    done_d       = done_q;
    found_d      = found_q;
    min_tm_d     = min_tm_q;
    min_tag_d    = min_tag_q;
    min_idx_d    = min_idx_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_tm_d     = out_tm_q;
    n_valid      = h_valid;
    n_tag        = h_tag;
    n_tm         = h_tm;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          done_d  = 1'b0;
          found_d = 1'b0;
        end
      end

      ST_SCAN: begin
        // Act on the entry passing the head.
        case (req_q)
          REQ_INSERT: begin
            if (!h_valid && !done_q) begin
              n_valid = 1'b1;
              n_tag   = tag_q;
              n_tm    = tm_q;
              done_d  = 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (h_valid && (h_tag == tag_q) && !done_q) begin
              n_valid = 1'b0;
              done_d  = 1'b1;
            end
          end
          REQ_ADJUST: begin
            if (h_valid && (h_tag == tag_q) && !done_q) begin
              n_tm   = tm_q;
              done_d = 1'b1;
            end
          end
          REQ_QUERY, REQ_FIRE: begin
            // Strict less-than keeps the lowest slot on ties.
            if (h_valid && (!found_q || (h_tm < min_tm_q))) begin
              found_d   = 1'b1;
              min_tm_d  = h_tm;
              min_tag_d = h_tag;
              min_idx_d = cnt_q;
            end
          end
          default: ;
        endcase

        cnt_d = cnt_q + 1'b1;
        if (last) begin
          cnt_d        = '0;
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_tag_d    = '0;
          out_tm_d     = '0;
          case (req_q)
            REQ_INSERT: begin
              if (!done_d) out_status_d = ST_FULL;
            end
            REQ_REMOVE, REQ_ADJUST: begin
              if (!done_d) out_status_d = ST_NOT_FOUND;
            end
            REQ_QUERY: begin
              if (!found_d) out_status_d = ST_EMPTY;
              else          out_tm_d     = min_tm_d;
            end
            REQ_FIRE: begin
              if (!found_d) begin
                out_status_d = ST_EMPTY;
              end else begin
                // Hold the response until the second rotation ends.
                out_valid_d = 1'b0;
                state_d     = ST_SWEEP;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SWEEP: begin
        // Advance every valid time by the elapsed amount; drop the fired one.
        if (h_valid) begin
          n_tm = h_tm - min_tm_q;
          if (cnt_q == min_idx_q) n_valid = 1'b0;
        end
        cnt_d = cnt_q + 1'b1;
        if (last) begin
          cnt_d        = '0;
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_tag_d    = min_tag_q;
          out_tm_d     = min_tm_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_i.req_type);
      tag_q <= req_i.event_tag;
      tm_q  <= req_i.event_time;
    end
    min_tm_q     <= min_tm_d;
    min_tag_q    <= min_tag_d;
    min_idx_q    <= min_idx_d;
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_tm_q     <= out_tm_d;
  end

endmodule

// ===== verif/tb_timed_event_list_core.sv =====
// Testbench for the timed event list core: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

class event_list_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fired_tag;
    logic [31:0] earliest_time;
  } outcome_t;

  bit          used [512];
  logic [31:0] due  [512];
  logic [7:0]  tags [512];
  outcome_t    pending_outcomes[$];
  int          errors;

  function int occupancy();
    int n;
    n = 0;
    foreach (used[k]) if (used[k]) n++;
    return n;
  endfunction

  // Advance the table model by one accepted request and queue its outcome.
  function void note_request(logic [2:0] req, logic [7:0] tag, logic [31:0] tm);
    outcome_t o;
    int hit;
    logic [31:0] el;
    o = '0;
    hit = -1;
    case (req)
      tel_pkg::REQ_INSERT: begin
        o.status = tel_pkg::ST_FULL;
        for (int s = 0; s < 512; s++) if (!used[s]) begin
          used[s] = 1; tags[s] = tag; due[s] = tm; o.status = tel_pkg::ST_OK;
          break;
        end
      end
      tel_pkg::REQ_REMOVE, tel_pkg::REQ_ADJUST: begin
        for (int s = 0; s < 512; s++) if (used[s] && tags[s] == tag) begin
          hit = s; break;
        end
        if (hit < 0) o.status = tel_pkg::ST_NOT_FOUND;
        else if (req == tel_pkg::REQ_REMOVE) used[hit] = 0;
        else due[hit] = tm;
      end
      tel_pkg::REQ_QUERY, tel_pkg::REQ_FIRE: begin
        for (int s = 0; s < 512; s++)
          if (used[s] && (hit < 0 || due[s] < due[hit])) hit = s;
        if (hit < 0) o.status = tel_pkg::ST_EMPTY;
        else begin
          el = due[hit];
          o.earliest_time = el;
          if (req == tel_pkg::REQ_FIRE) begin
            o.fired_tag = tags[hit];
            foreach (used[k]) if (used[k]) due[k] = due[k] - el;
            used[hit] = 0;
          end
        end
      end
      default: ;
    endcase
    pending_outcomes.push_back(o);
  endfunction

  function void check_response(logic [1:0] st, logic [7:0] ft, logic [31:0] et);
    outcome_t e;
    if (pending_outcomes.size() == 0) begin
      $error("response with nothing outstanding"); errors++; return;
    end
    e = pending_outcomes.pop_front();
    if (st !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, st); errors++;
    end
    if (ft !== e.fired_tag) begin
      $error("fired_tag: expected %0d, got %0d", e.fired_tag, ft); errors++;
    end
    if (et !== e.earliest_time) begin
      $error("earliest_time: expected %0d, got %0d", e.earliest_time, et); errors++;
    end
  endfunction
endclass

module tb_timed_event_list_core;
  import tel_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  always #1 clk_i = ~clk_i;

  tel_req_if req_if ();
  tel_rsp_if rsp_if ();

  timed_event_list_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  event_list_scoreboard board = new();
  int  hold_cycles = 0;   // long receiver hold-off requested by the driver
  logic [7:0] live_tags[$];

  initial begin
    req_if.valid = 0;
    req_if.req_type = '0;
    req_if.event_tag = '0;
    req_if.event_time = '0;
    rsp_if.ready = 0;
  end

  // Pick a gap length: mostly zero or short, sometimes long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(1200, 100);
  endfunction

  // Offer one transaction and hold it until accepted; note it in the scoreboard.
  task automatic send_request(logic [2:0] req, logic [7:0] tag, logic [31:0] tm);
    req_if.valid      <= 1;
    req_if.req_type   <= req;
    req_if.event_tag  <= tag;
    req_if.event_time <= tm;
    do @(posedge clk_i); while (!req_if.ready);
    board.note_request(req, tag, tm);
    if (req == REQ_INSERT && board.pending_outcomes[$].status == ST_OK)
      live_tags.push_back(tag);
  endtask

  task automatic idle_sender(int n);
    if (n == 0) return;
    req_if.valid <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (board.pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_time();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  // Pick a tag: usually one inserted earlier, so remove and adjust tend to hit.
  function automatic logic [7:0] pick_tag();
    if (live_tags.size() != 0 && $urandom_range(3) != 0)
      return live_tags[$urandom_range(live_tags.size() - 1)];
    return 8'($urandom());
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        board.check_response(rsp_if.status, rsp_if.fired_tag, rsp_if.earliest_time);
    end
  end

  initial begin
    int g;
    wait (rst_ni);
    forever begin
      if (hold_cycles != 0) begin
        rsp_if.ready <= 0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          rsp_if.ready <= 0;
          repeat (g > 300 ? 300 : g) @(posedge clk_i);
        end
      end
      rsp_if.ready <= 1;
      @(posedge clk_i);
    end
  end

  initial begin
    int r;
    logic [2:0] req;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty table, unknown codes, boundary values, duplicates, ties.
    send_request(REQ_QUERY, 8'h00, 32'h0);
    send_request(REQ_FIRE, 8'hFF, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 8'h12, 32'h0);
    send_request(REQ_ADJUST, 8'hFF, 32'h5);
    send_request(3'd5, 8'hAA, 32'h1234);
    send_request(3'd6, 8'h55, 32'hFFFF_FFFF);
    send_request(3'd7, 8'hFF, 32'h0);
    send_request(REQ_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 8'h00, 32'h0);
    send_request(REQ_INSERT, 8'h07, 32'd100);
    send_request(REQ_INSERT, 8'h07, 32'd100);
    send_request(REQ_QUERY, 8'h00, 32'h0);
    send_request(REQ_FIRE, 8'h00, 32'h0);
    send_request(REQ_FIRE, 8'h00, 32'h0);
    send_request(REQ_ADJUST, 8'h07, 32'd3);
    send_request(REQ_REMOVE, 8'h07, 32'h0);
    send_request(REQ_FIRE, 8'h00, 32'h0);
    send_request(REQ_FIRE, 8'h00, 32'h0);
    send_request(REQ_FIRE, 8'h00, 32'h0);

    // Fill to capacity with the receiver held off, so the input stalls.
    hold_cycles = 3000;
    for (int k = 0; k < 512; k++) send_request(REQ_INSERT, k[7:0], $urandom_range(4000));
    send_request(REQ_INSERT, 8'h99, 32'h1);
    send_request(REQ_QUERY, 8'h0, 32'h0);
    drain();
    for (int k = 0; k < 40; k++) send_request(REQ_FIRE, 8'h0, 32'h0);
    drain();
    live_tags.delete();
    foreach (board.used[k]) if (board.used[k]) live_tags.push_back(board.tags[k]);

    // Random part: keep occupancy small-ish by biasing toward fire when busy.
    for (int n = 0; n < 580; n++) begin
      r = $urandom_range(99);
      if (r < 3) req = 3'($urandom_range(7, 5));
      else if (r < 30) req = board.occupancy() > 480 ? REQ_FIRE : REQ_INSERT;
      else if (r < 45) req = REQ_REMOVE;
      else if (r < 60) req = REQ_ADJUST;
      else if (r < 72) req = REQ_QUERY;
      else req = REQ_FIRE;
      send_request(req, req == REQ_INSERT ? 8'($urandom()) : pick_tag(), random_time());
      if (n == 300) drain();
      idle_sender(gap_len() > 300 ? 40 : gap_len());
    end
    drain();
    repeat (1100) @(posedge clk_i);
    if (board.errors == 0 && board.pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/tel_pkg.sv
hdl/tel_if.sv
hdl/tel_cell.sv
hdl/timed_event_list_core.sv
verif/tb_timed_event_list_core.sv
